### sv/text_console_cell_writer_top_assert.svh
// assertion macros for the text console cell writer
// used by modules that check their own control logic; expects clk and rst_n in scope
`ifndef TEXT_CONSOLE_CELL_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_TOP_ASSERT_SVH

// same-cycle implication
`define TCCW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tccw_pkg.sv
// shared types and constants for the text console cell writer
// no dependencies; imported by datapath, controller and top level
`default_nettype none

package tccw_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int IN_W  = 24;
  localparam int OUT_W = 40;
  localparam int IDX_W = 11;
  localparam int OROW_W = 5;
  localparam int OCOL_W = 7;
  localparam int OPOS_W = 11;
  localparam int CELL_W = 16;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] KEY_NEWLINE   = 8'd10;
  localparam logic [7:0] KEY_BACKSPACE = 8'd8;
  localparam logic [7:0] BLANK_GLYPH   = 8'h20;
  localparam logic [7:0] ATTR_RESET    = 8'h07;

  typedef enum logic [1:0] {
    SWEEP_ZERO,
    SWEEP_BLANK,
    SWEEP_SCROLL
  } sweep_mode_t;

  typedef struct packed {
    logic        latch;
    logic        put;
    logic        home;
    logic        sweep;
    logic        cnt_clr;
    logic        load;
    sweep_mode_t mode;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       scroll_need;
    logic       sweep_last;
  } dp_status_t;

endpackage

`default_nettype wire

### sv/tccw_datapath.sv
// datapath: screen store, cursor registers, sweep counter and result register
// depends on tccw_pkg; driven by tccw_ctrl commands
`default_nettype none

module tccw_datapath
  import tccw_pkg::*;
#(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data,
  input  wire dp_cmd_t          cmd,
  output dp_status_t            st,
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int CELLS  = COLS * ROWS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(CELLS);

  logic [15:0]       mem [CELLS];
  logic [15:0]       mem_q_r;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] cnt_r;
  logic [7:0]        attr_r;
  logic [1:0]        op_r;
  logic [7:0]        char_r;
  logic [IDX_W-1:0]  idx_r;
  logic [OUT_W-1:0]  out_r;

  logic              adv;
  logic              overflow;
  logic [ADDR_W-1:0] row_start;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic [15:0]       blank;
  logic [31:0]       rd_full;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       row_ext, col_ext, pos_ext;
  logic [15:0]       cell_res;

  assign cfg_ready = 1'b1;
  assign blank     = {attr_r, BLANK_GLYPH};
  assign row_start = pos_r - ADDR_W'(col_r);

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    pos_nxt  = pos_r;
    adv      = 1'b0;
    overflow = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = cnt_r;
    wr_data  = blank;
    if (cmd.home) begin
      row_nxt = '0;
      col_nxt = '0;
      pos_nxt = '0;
    end else if (cmd.put) begin
      if (char_r == KEY_NEWLINE) begin
        adv = 1'b1;
      end else if (char_r == KEY_BACKSPACE) begin
        if (col_r != '0) begin
          col_nxt = col_r - COL_W'(1);
          pos_nxt = pos_r - ADDR_W'(1);
          wr_en   = 1'b1;
          wr_addr = pos_r - ADDR_W'(1);
          wr_data = blank;
        end
      end else begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = {attr_r, char_r};
        if (col_r == COL_W'(COLS - 1)) begin
          adv = 1'b1;
        end else begin
          col_nxt = col_r + COL_W'(1);
          pos_nxt = pos_r + ADDR_W'(1);
        end
      end
      if (adv) begin
        col_nxt = '0;
        if (row_r == ROW_W'(ROWS - 1)) begin
          overflow = 1'b1;
          pos_nxt  = row_start;
        end else begin
          row_nxt = row_r + ROW_W'(1);
          pos_nxt = row_start + ADDR_W'(COLS);
        end
      end
    end else if (cmd.sweep) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r;
      case (cmd.mode)
        SWEEP_ZERO:   wr_data = 16'h0000;
        SWEEP_BLANK:  wr_data = blank;
        SWEEP_SCROLL: wr_data = (32'(cnt_r) < 32'(CELLS - COLS)) ? mem_q_r : blank;
        default:      wr_data = blank;
      endcase
    end
  end

  // read port: item index on accept, lookahead row during scroll
  always_comb begin
    rd_full = 32'(CELLS);
    if (cmd.latch) begin
      rd_full = 32'(in_tdata[20:10]);
    end else if (cmd.put) begin
      rd_full = 32'(COLS);
    end else if (cmd.sweep) begin
      rd_full = 32'(cnt_r) + 32'(COLS) + 32'd1;
    end
  end

  assign rd_en   = (cmd.latch || cmd.put || cmd.sweep) && (rd_full < 32'(CELLS));
  assign rd_addr = rd_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign row_ext  = 32'(row_nxt);
  assign col_ext  = 32'(col_nxt);
  assign pos_ext  = 32'(pos_nxt);
  assign cell_res = (op_r == OP_READ && 32'(idx_r) < 32'(CELLS)) ? mem_q_r : 16'h0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      pos_r  <= '0;
      cnt_r  <= '0;
      attr_r <= ATTR_RESET;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      pos_r <= pos_nxt;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.sweep) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_tdata[1:0];
      char_r <= in_tdata[9:2];
      idx_r  <= in_tdata[20:10];
    end
    if (cmd.load) begin
      out_r <= {1'b0, cell_res, pos_ext[OPOS_W-1:0], col_ext[OCOL_W-1:0],
                row_ext[OROW_W-1:0]};
    end
  end

  assign out_tdata      = out_r;
  assign st.op          = op_r;
  assign st.scroll_need = overflow;
  assign st.sweep_last  = (32'(cnt_r) == 32'(CELLS - 1));

endmodule

`default_nettype wire

### sv/tccw_ctrl.sv
// controller: sequences accept, execute, store sweeps and result handoff
// depends on tccw_pkg and text_console_cell_writer_top_assert.svh
`default_nettype none

module tccw_ctrl
  import tccw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire dp_status_t  st,
  output dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  sweep_mode_t mode_r, mode_nxt;
  logic        finish;
  logic        out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd.latch   = 1'b0;
    cmd.put     = 1'b0;
    cmd.home    = 1'b0;
    cmd.sweep   = 1'b0;
    cmd.cnt_clr = 1'b0;
    cmd.load    = 1'b0;
    cmd.mode    = mode_r;
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    finish      = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (st.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (st.op)
          OP_PUT: begin
            cmd.put = 1'b1;
            if (st.scroll_need) begin
              cmd.cnt_clr = 1'b1;
              mode_nxt    = SWEEP_SCROLL;
              state_nxt   = ST_SWEEP;
            end else begin
              finish = 1'b1;
            end
          end
          OP_CLEAR: begin
            cmd.home    = 1'b1;
            cmd.cnt_clr = 1'b1;
            mode_nxt    = SWEEP_BLANK;
            state_nxt   = ST_SWEEP;
          end
          default: finish = 1'b1;
        endcase
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (st.sweep_last) begin
          finish = 1'b1;
        end
      end
      ST_DONE: finish = 1'b1;
      default: state_nxt = ST_IDLE;
    endcase
    if (finish) begin
      if (out_free) begin
        cmd.load  = 1'b1;
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = ST_DONE;
      end
    end
    out_valid_nxt = cmd.load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
      mode_r      <= SWEEP_ZERO;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
  end

`include "text_console_cell_writer_top_assert.svh"

  `TCCW_ASSERT_IMPLY(a_no_overwrite, cmd.load && out_valid_r, out_tready, "result register overwritten")
  `TCCW_ASSERT_NEXT(a_accept_exec, in_tvalid && in_tready, state_r == ST_EXEC, "accept not followed by execute")
  `TCCW_ASSERT_NEXT(a_sweep_ends, state_r == ST_SWEEP && st.sweep_last, state_r != ST_SWEEP, "sweep ran past last cell")

endmodule

`default_nettype wire

### sv/text_console_cell_writer_top.sv
// Text console cell writer. Channels: in_* carries one command per transaction
// (put character, clear screen, read cell); out_* returns one result per command
// with the cursor row, column and linear position, and the cell read by a read.
// cfg_* writes the attribute byte used for written and blanked cells; it is always
// ready and should only be written while no command is in flight.
// A put without scroll, a read or an unused opcode is latched on accept, then executed
// and its result loaded into the output register, with in_tready low until it finishes.
// A clear, or a put that moves the cursor past the bottom row, walks every cell of
// the screen store once through its single write port. After reset a clearing pass
// zeroes the store with in_tready low; cursor homes and the attribute returns to 0x07.
// The result sits in an output register; a new command is accepted while it waits,
// and if out_tready stays low the next result is held inside until the register
// frees, with in_tready low meanwhile.
// depends on tccw_pkg, tccw_datapath, tccw_ctrl
`default_nettype none

module text_console_cell_writer_top
  import tccw_pkg::*;
#(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // opcode, char_code, cell_index, zero pad
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // cursor_row, cursor_col, cursor_pos, cell_value, zero pad
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  tccw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  tccw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire
